@@ src/omni_wheel_speed_from_twist_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the omni wheel speed block
// Expect clk and rst_n in the scope of each use.
// ---------------------------------------------------------------------------
`ifndef OMNI_WHEEL_SPEED_FROM_TWIST_MACROS_SVH
`define OMNI_WHEEL_SPEED_FROM_TWIST_MACROS_SVH

`define OWST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("omni wheel speed check failed");

`define OWST_ASSERT_NEVER(lbl, bad) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error("omni wheel speed check failed");

`endif

@@ src/owst_pkg.sv @@
// ---------------------------------------------------------------------------
// owst_pkg
// Shared constants and codes of the omni wheel speed pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package owst_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int LATENCY = 17;
  localparam int ADDR_W = 5;
  localparam int K_MAX = 13;

  localparam logic [33:0] HALF_PI_Q28 = 34'd421657428;
  localparam logic [33:0] QUARTER_PI_Q28 = 34'd210828714;
  localparam logic [34:0] EIGHT_HALF_PI = 35'd3373259424;
  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

  localparam int DIV_SHIFT = 35;
  localparam logic [32:0] RECIP_6 = 33'(((64'd1 << DIV_SHIFT) + 64'd5) / 64'd6);
  localparam logic [32:0] RECIP_12 = 33'(((64'd1 << DIV_SHIFT) + 64'd11) / 64'd12);
  localparam logic [32:0] RECIP_20 = 33'(((64'd1 << DIV_SHIFT) + 64'd19) / 64'd20);
  localparam logic [32:0] RECIP_30 = 33'(((64'd1 << DIV_SHIFT) + 64'd29) / 64'd30);
  localparam logic [32:0] RECIP_42 = 33'(((64'd1 << DIV_SHIFT) + 64'd41) / 64'd42);
  localparam logic [32:0] RECIP_56 = 33'(((64'd1 << DIV_SHIFT) + 64'd55) / 64'd56);

  typedef enum logic [2:0] {
    REG_POS_X      = 3'd0,
    REG_POS_Y      = 3'd1,
    REG_SIN        = 3'd2,
    REG_COS        = 3'd3,
    REG_POSE_VALID = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

endpackage

`default_nettype wire

@@ src/owst_trig.sv @@
// ---------------------------------------------------------------------------
// owst_trig
// Pipelined sine and cosine of a Q4.12 angle, range reduced to a quarter
// turn, polynomial in Q28, rounded to Q(TRIG_FRAC_BITS). Ten stages.
// ---------------------------------------------------------------------------
`default_nettype none

module owst_trig
  import owst_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_vld,
  input  wire logic signed [15:0]               in_angle,
  output logic                                  out_vld,
  output logic signed [TRIG_FRAC_BITS+1:0]      out_sin,
  output logic signed [TRIG_FRAC_BITS+1:0]      out_cos
);

  localparam int F = TRIG_FRAC_BITS;
  localparam int SH = 28 - F;
  localparam logic [28:0] RND = 29'(1) << (SH - 1);

  function automatic logic [28:0] mul28u(logic [28:0] a, logic [28:0] b);
    logic [57:0] p;
    p = {29'd0, a} * {29'd0, b};
    return p[56:28];
  endfunction

  function automatic logic [28:0] one_minus_div(logic [28:0] v, logic [32:0] m);
    logic [61:0] p;
    p = {33'd0, v} * {29'd0, m};
    return ONE_Q28 - {2'b00, p[61:35]};
  endfunction

  logic        vld_r [1:10];
  logic [3:0]  k_r   [1:9];
  logic        rneg_r [2:9];
  logic [27:0] rmag_r [2:8];
  logic [28:0] r2_r  [3:8];
  logic [33:0] u_r;
  logic [28:0] ts4_r, tc4_r, ps5_r, pc5_r, ts6_r, tc6_r;
  logic [28:0] ps7_r, pc7_r, ts8_r, tc8_r, smag_r, pc9_r;
  logic signed [F+1:0] sin_r, cos_r;

  logic signed [34:0] u_sum;
  logic [33:0] u_nxt;
  logic [3:0]  k_nxt;
  logic [33:0] thr;
  logic [33:0] khp;
  logic signed [34:0] r_sum, r_abs;
  logic [55:0] rsq;
  logic [28:0] ts4_nxt, tc4_nxt, ps5_nxt, pc5_nxt, ts6_nxt, tc6_nxt;
  logic [28:0] ps7_nxt, pc7_nxt, ts8_nxt, tc8_nxt, smag_nxt, pc9_nxt;
  logic [28:0] c_full, s_rnd, c_rnd;
  logic signed [F+1:0] s_pos, c_pos, s_val, sin_nxt, cos_nxt;

  assign u_sum = (35'(in_angle) <<< 16) + $signed(EIGHT_HALF_PI);
  assign u_nxt = u_sum[33:0];

  always_comb begin
    thr = '0;
    k_nxt = '0;
    for (int j = 1; j <= K_MAX; j++) begin
      thr = 34'(j) * HALF_PI_Q28 - QUARTER_PI_Q28;
      if (u_nxt >= thr) k_nxt = k_nxt + 4'd1;
    end
  end

  assign khp   = 34'(k_r[1]) * HALF_PI_Q28;
  assign r_sum = $signed({1'b0, u_r}) - $signed({1'b0, khp});
  assign r_abs = r_sum[34] ? -r_sum : r_sum;
  assign rsq   = {28'd0, rmag_r[2]} * {28'd0, rmag_r[2]};

  assign ts4_nxt = one_minus_div(r2_r[3], RECIP_42);
  assign tc4_nxt = one_minus_div(r2_r[3], RECIP_56);
  assign ps5_nxt = mul28u(r2_r[4], ts4_r);
  assign pc5_nxt = mul28u(r2_r[4], tc4_r);
  assign ts6_nxt = one_minus_div(ps5_r, RECIP_20);
  assign tc6_nxt = one_minus_div(pc5_r, RECIP_30);
  assign ps7_nxt = mul28u(r2_r[6], ts6_r);
  assign pc7_nxt = mul28u(r2_r[6], tc6_r);
  assign ts8_nxt = one_minus_div(ps7_r, RECIP_6);
  assign tc8_nxt = one_minus_div(pc7_r, RECIP_12);
  assign smag_nxt = mul28u({1'b0, rmag_r[8]}, ts8_r);
  assign pc9_nxt  = mul28u(r2_r[8], tc8_r);

  assign c_full = ONE_Q28 - {1'b0, pc9_r[28:1]};
  assign s_rnd  = (smag_r + RND) >> SH;
  assign c_rnd  = (c_full + RND) >> SH;
  assign s_pos  = $signed({1'b0, s_rnd[F:0]});
  assign c_pos  = $signed({1'b0, c_rnd[F:0]});
  assign s_val  = rneg_r[9] ? -s_pos : s_pos;

  always_comb begin
    case (quad_t'(k_r[9][1:0]))
      QUAD_0: begin
        sin_nxt = s_val;
        cos_nxt = c_pos;
      end
      QUAD_1: begin
        sin_nxt = c_pos;
        cos_nxt = -s_val;
      end
      QUAD_2: begin
        sin_nxt = -s_val;
        cos_nxt = -c_pos;
      end
      default: begin
        sin_nxt = -c_pos;
        cos_nxt = s_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 10; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[1] <= in_vld;
      for (int i = 2; i <= 10; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    k_r[1] <= k_nxt;
    for (int i = 2; i <= 9; i++) k_r[i] <= k_r[i-1];
    rneg_r[2] <= r_sum[34];
    for (int i = 3; i <= 9; i++) rneg_r[i] <= rneg_r[i-1];
    rmag_r[2] <= r_abs[27:0];
    for (int i = 3; i <= 8; i++) rmag_r[i] <= rmag_r[i-1];
    r2_r[3] <= {1'b0, rsq[55:28]};
    for (int i = 4; i <= 8; i++) r2_r[i] <= r2_r[i-1];
    ts4_r  <= ts4_nxt;
    tc4_r  <= tc4_nxt;
    ps5_r  <= ps5_nxt;
    pc5_r  <= pc5_nxt;
    ts6_r  <= ts6_nxt;
    tc6_r  <= tc6_nxt;
    ps7_r  <= ps7_nxt;
    pc7_r  <= pc7_nxt;
    ts8_r  <= ts8_nxt;
    tc8_r  <= tc8_nxt;
    smag_r <= smag_nxt;
    pc9_r  <= pc9_nxt;
    sin_r  <= sin_nxt;
    cos_r  <= cos_nxt;
  end

  assign out_vld = vld_r[10];
  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule

`default_nettype wire

@@ src/omni_wheel_speed_from_twist.sv @@
// ---------------------------------------------------------------------------
// omni_wheel_speed_from_twist
// Speed of one omni wheel from a velocity command and the wheel pose.
// ---------------------------------------------------------------------------
// One command word is taken in every cycle; busy never rises. Each result
// appears on the out_ ports with out_strobe for one cycle, in command
// order, through a 17-stage datapath: ten stages of sine and cosine, then
// the wheel offset, rounding, projection and saturation. Results are not
// held, so the receiver must take each one when it shows. Write the wheel
// registers while no command is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module omni_wheel_speed_from_twist
  import owst_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [23:0]   in_linear_x,
  input  wire logic signed [23:0]   in_linear_y,
  input  wire logic signed [15:0]   in_turn_angle,
  output logic                      out_strobe,
  output logic signed [31:0]        out_speed_fixed,
  output logic signed [15:0]        out_speed_hundredths,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_W-1:0]    paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int F  = TRIG_FRAC_BITS;
  localparam int PW = F + 26;
  localparam int SW = F + 30;
  localparam int XW = 30;
  localparam int MW = 46;

  logic signed [23:0] pos_x_r, pos_y_r;
  logic signed [15:0] wsin_r, wcos_r;
  logic               pose_r;
  logic               wr_en;
  reg_idx_t           idx;

  logic               tvld;
  logic signed [F+1:0] tsin, tcos;

  logic signed [23:0] lx_r [1:11];
  logic signed [23:0] ly_r [1:11];
  logic               vld_r [11:16];

  logic signed [PW-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [PW-1:0] pxc_nxt, pys_nxt, pxs_nxt, pyc_nxt;
  logic signed [SW-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic [SW-1:0]        xabs, yabs, xsh, ysh;
  logic [XW-1:0]        xm, ym;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [MW-1:0] mx_r, my_r, mx_nxt, my_nxt;
  logic signed [46:0]   s_r, s_nxt, s_abs;
  logic [32:0]          fm_r, fm_nxt;
  logic [53:0]          hm_r, hm_nxt;
  logic                 sneg_r;
  logic [23:0]          hq;
  logic signed [31:0]   fixed_r, fixed_nxt;
  logic signed [15:0]   hund_r, hund_nxt;
  logic                 strobe_r;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      wsin_r  <= '0;
      wcos_r  <= 16'sd16384;
      pose_r  <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_POS_X:      pos_x_r <= pwdata[23:0];
        REG_POS_Y:      pos_y_r <= pwdata[23:0];
        REG_SIN:        wsin_r  <= pwdata[15:0];
        REG_COS:        wcos_r  <= pwdata[15:0];
        REG_POSE_VALID: pose_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POS_X:      prdata = {8'd0, pos_x_r};
      REG_POS_Y:      prdata = {8'd0, pos_y_r};
      REG_SIN:        prdata = {16'd0, wsin_r};
      REG_COS:        prdata = {16'd0, wcos_r};
      REG_POSE_VALID: prdata = {31'd0, pose_r};
      default:        prdata = '0;
    endcase
  end

  owst_trig #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start & ~busy),
    .in_angle(in_turn_angle),
    .out_vld (tvld),
    .out_sin (tsin),
    .out_cos (tcos)
  );

  assign pxc_nxt = PW'(tcos) * PW'(pos_x_r);
  assign pys_nxt = PW'(tsin) * PW'(pos_y_r);
  assign pxs_nxt = PW'(tsin) * PW'(pos_x_r);
  assign pyc_nxt = PW'(tcos) * PW'(pos_y_r);

  assign sx_nxt = (SW'(lx_r[11]) <<< F) + ((SW'(pxc_r) - SW'(pys_r)) <<< 3)
                - (SW'(pos_x_r) <<< (F + 3));
  assign sy_nxt = (SW'(ly_r[11]) <<< F) + ((SW'(pxs_r) + SW'(pyc_r)) <<< 3)
                - (SW'(pos_y_r) <<< (F + 3));

  assign xabs  = sx_r[SW-1] ? SW'(-sx_r) : SW'(sx_r);
  assign yabs  = sy_r[SW-1] ? SW'(-sy_r) : SW'(sy_r);
  assign xsh   = (xabs + (SW'(1) << (F - 1))) >> F;
  assign ysh   = (yabs + (SW'(1) << (F - 1))) >> F;
  assign xm    = xsh[XW-1:0];
  assign ym    = ysh[XW-1:0];
  assign x_nxt = sx_r[SW-1] ? -$signed(xm) : $signed(xm);
  assign y_nxt = sy_r[SW-1] ? -$signed(ym) : $signed(ym);

  assign mx_nxt = MW'(x_r) * MW'(wsin_r);
  assign my_nxt = MW'(y_r) * MW'(wcos_r);
  assign s_nxt  = 47'(mx_r) - 47'(my_r);

  assign s_abs  = s_r[46] ? -s_r : s_r;
  assign fm_nxt = 33'(($unsigned(s_abs) + 47'd8192) >> 14);
  assign hm_nxt = {7'd0, $unsigned(s_abs)} * 54'd100;

  assign hq = hm_r[53:30];

  always_comb begin
    if (sneg_r) begin
      fixed_nxt = (fm_r > 33'h0_8000_0000) ? 32'sh8000_0000 : -$signed(fm_r[31:0]);
      hund_nxt  = (hq > 24'd32768) ? 16'sh8000 : -$signed(hq[15:0]);
    end else begin
      fixed_nxt = (fm_r > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(fm_r[31:0]);
      hund_nxt  = (hq > 24'd32767) ? 16'sh7FFF : $signed(hq[15:0]);
    end
    if (!pose_r) begin
      fixed_nxt = '0;
      hund_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 11; i <= 16; i++) vld_r[i] <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      vld_r[11] <= tvld;
      for (int i = 12; i <= 16; i++) vld_r[i] <= vld_r[i-1];
      strobe_r <= vld_r[16];
    end
  end

  always_ff @(posedge clk) begin
    lx_r[1] <= in_linear_x;
    ly_r[1] <= in_linear_y;
    for (int i = 2; i <= 11; i++) begin
      lx_r[i] <= lx_r[i-1];
      ly_r[i] <= ly_r[i-1];
    end
    pxc_r   <= pxc_nxt;
    pys_r   <= pys_nxt;
    pxs_r   <= pxs_nxt;
    pyc_r   <= pyc_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    mx_r    <= mx_nxt;
    my_r    <= my_nxt;
    s_r     <= s_nxt;
    fm_r    <= fm_nxt;
    hm_r    <= hm_nxt;
    sneg_r  <= s_r[46];
    fixed_r <= fixed_nxt;
    hund_r  <= hund_nxt;
  end

  assign out_strobe           = strobe_r;
  assign out_speed_fixed      = fixed_r;
  assign out_speed_hundredths = hund_r;

endmodule

`default_nettype wire

@@ src/owst_checker.sv @@
// ---------------------------------------------------------------------------
// owst_checker
// Port-level checks of the omni wheel speed block, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "omni_wheel_speed_from_twist_macros.svh"

module owst_checker
  import owst_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire logic signed [31:0] out_speed_fixed,
  input wire logic signed [15:0] out_speed_hundredths
);

  `OWST_ASSERT_IMP(a_latency, start && !busy, ##LATENCY out_strobe)
  `OWST_ASSERT_IMP(a_no_orphan, out_strobe, $past(start && !busy, LATENCY))
  `OWST_ASSERT_NEVER(a_sign, out_strobe && (out_speed_hundredths > 16'sd0) && (out_speed_fixed <= 32'sd0))
  `OWST_ASSERT_IMP(a_sat, out_strobe && (out_speed_fixed == 32'sh7FFF_FFFF), out_speed_hundredths == 16'sh7FFF)

endmodule

bind omni_wheel_speed_from_twist owst_checker u_owst_checker (.*);

`default_nettype wire

@@ tb/tb_omni_wheel_speed_from_twist.sv @@
// ---------------------------------------------------------------------------
// tb_omni_wheel_speed_from_twist
// Self-checking bench for the omni wheel speed pipeline.
// ---------------------------------------------------------------------------
// Commands are driven on the start/busy port and each accepted word is
// predicted by a scoreboard that holds its own copy of the wheel registers.
// Every strobed result is compared field by field in order. Registers are
// written over the APB-style port between phases, with extreme and random
// wheel poses, under three sender idle profiles.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_omni_wheel_speed_from_twist;
  import owst_pkg::*;

  localparam int FRAC = TRIG_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] REG_UNMAPPED_LO = 3'd5;
  localparam logic [2:0] REG_UNMAPPED_HI = 3'd7;
  localparam longint HALF_PI = 64'sd421657428;
  localparam longint Q28 = 64'sd1 << 28;

  typedef struct {
    logic signed [31:0] fixed;
    logic signed [15:0] hund;
  } wheel_speed_t;

  class wheel_speed_board;
    logic signed [23:0] pos_x, pos_y;
    logic signed [15:0] w_sin, w_cos;
    logic               pose_ok;
    wheel_speed_t       pending_q[$];

    function new();
      pos_x = '0; pos_y = '0; w_sin = '0; w_cos = 16'sd16384; pose_ok = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_POS_X:      pos_x = v[23:0];
        REG_POS_Y:      pos_y = v[23:0];
        REG_SIN:        w_sin = v[15:0];
        REG_COS:        w_cos = v[15:0];
        REG_POSE_VALID: pose_ok = v[0];
        default: ;
      endcase
    endfunction

    function longint rnd_shift(longint v, int sh);
      longint m;
      m = ((v < 0 ? -v : v) + (64'sd1 << (sh - 1))) >>> sh;
      return v < 0 ? -m : m;
    endfunction

    function longint qmul(longint a, longint b);
      longint m;
      m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> 28;
      return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function void sincos(longint ang, output longint sn, output longint cs);
      longint u, k, r, r2, t, c, s;
      u = ang * 65536 + 8 * HALF_PI;
      k = (u + HALF_PI / 2) / HALF_PI;
      r = u - k * HALF_PI;
      r2 = qmul(r, r);
      t = Q28 - r2 / 42;
      t = Q28 - qmul(r2, t) / 20;
      t = Q28 - qmul(r2, t) / 6;
      s = qmul(r, t);
      c = Q28 - r2 / 56;
      c = Q28 - qmul(r2, c) / 30;
      c = Q28 - qmul(r2, c) / 12;
      c = Q28 - qmul(r2, c) / 2;
      case (quad_t'(k[1:0]))
        QUAD_0: begin sn = s;  cs = c;  end
        QUAD_1: begin sn = c;  cs = -s; end
        QUAD_2: begin sn = -s; cs = -c; end
        default: begin sn = -c; cs = s; end
      endcase
      sn = rnd_shift(sn, 28 - FRAC);
      cs = rnd_shift(cs, 28 - FRAC);
    endfunction

    function void note_command(logic signed [23:0] lx, logic signed [23:0] ly,
                               logic signed [15:0] ang);
      wheel_speed_t e;
      longint sn, cs, px, py, x, y, s, f, h;
      e.fixed = '0;
      e.hund = '0;
      if (pose_ok) begin
        px = pos_x;
        py = pos_y;
        sincos(longint'(ang), sn, cs);
        x = longint'(lx) * (64'sd1 << FRAC) + 8 * (cs * px - sn * py)
            - 8 * px * (64'sd1 << FRAC);
        y = longint'(ly) * (64'sd1 << FRAC) + 8 * (sn * px + cs * py)
            - 8 * py * (64'sd1 << FRAC);
        x = rnd_shift(x, FRAC);
        y = rnd_shift(y, FRAC);
        s = x * longint'(w_sin) - y * longint'(w_cos);
        f = rnd_shift(s, 14);
        if (f > 64'sd2147483647) f = 64'sd2147483647;
        if (f < -64'sd2147483648) f = -64'sd2147483648;
        h = (s * 100) / (64'sd1 << 30);
        if (h > 32767) h = 32767;
        if (h < -32768) h = -32768;
        e.fixed = f[31:0];
        e.hund = h[15:0];
      end
      pending_q.push_back(e);
    endfunction

    function string check_result(logic signed [31:0] f, logic signed [15:0] h);
      wheel_speed_t e;
      if (pending_q.size() == 0) return "result word with no command pending";
      e = pending_q.pop_front();
      if (f !== e.fixed || h !== e.hund)
        return $sformatf("speed_fixed %0d (exp %0d) speed_hundredths %0d (exp %0d)",
                         f, e.fixed, h, e.hund);
      return "";
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [23:0] in_linear_x = '0;
  logic signed [23:0] in_linear_y = '0;
  logic signed [15:0] in_turn_angle = '0;
  logic out_strobe;
  logic signed [31:0] out_speed_fixed;
  logic signed [15:0] out_speed_hundredths;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  wheel_speed_board board = new();
  int fails = 0;
  int words_in = 0;
  int words_out = 0;
  int cycles = 0;

  omni_wheel_speed_from_twist dut (
    .clk, .rst_n, .start, .busy, .in_linear_x, .in_linear_y, .in_turn_angle,
    .out_strobe, .out_speed_fixed, .out_speed_hundredths,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(string msg);
    fails++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(negedge clk) begin
    string msg;
    if (rst_n && out_strobe) begin
      words_out++;
      msg = board.check_result(out_speed_fixed, out_speed_hundredths);
      if (msg != "") report(msg);
    end
  end

  task automatic send(logic signed [23:0] lx, logic signed [23:0] ly,
                      logic signed [15:0] ang, int idle_pct);
    logic ok;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_linear_x <= lx;
    in_linear_y <= ly;
    in_turn_angle <= ang;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    board.note_command(lx, ly, ang);
    words_in++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic set_pose(logic [31:0] px, logic [31:0] py, logic [31:0] ws,
                          logic [31:0] wc, logic [31:0] pv);
    cfg_write(REG_POS_X, px);
    cfg_write(REG_POS_Y, py);
    cfg_write(REG_SIN, ws);
    cfg_write(REG_COS, wc);
    cfg_write(REG_POSE_VALID, pv);
    cfg_write(logic'($urandom_range(1)) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI, $urandom);
  endtask

  function automatic logic [31:0] trig_reg();
    int r;
    if ($urandom_range(7) == 0) return $urandom;
    r = $urandom_range(32768);
    return 32'(r - 16384);
  endfunction

  function automatic logic signed [23:0] vel();
    int r;
    if ($urandom_range(1)) return 24'($urandom);
    r = $urandom_range(1 << 19);
    return 24'(r - (1 << 18));
  endfunction

  initial begin
    logic signed [15:0] dir_ang[12];
    dir_ang = '{16'sd0, 16'sd1, -16'sd1, 16'sd3217, 16'sd3218, 16'sd6434,
                -16'sd6434, 16'sd12868, 16'sd19302, 16'sd32767, -16'sd32768, 16'sd9651};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pose unknown after reset: zero output
    send(24'sh7FFFFF, -24'sh800000, 16'sd1234, 0);
    send(-24'sh800000, 24'sh7FFFFF, -16'sd32768, 0);
    drain();

    set_pose(32'h007FFFFF, 32'hFF800000, 32'd16384, 32'hFFFFC000, 32'd1);
    foreach (dir_ang[i]) send(24'sh7FFFFF, -24'sh800000, dir_ang[i], 0);
    send(24'sd0, 24'sd0, 16'sd0, 0);
    send(-24'sh800000, -24'sh800000, 16'sd32767, 0);
    drain();
    set_pose(32'hFF800000, 32'h007FFFFF, 32'h00007FFF, 32'h00008000, 32'd1);
    foreach (dir_ang[i]) send(-24'sh800000, 24'sh7FFFFF, dir_ang[i], 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      int idle;
      idle = (ph == 0) ? 32 : (ph == 1) ? 58 : 0;
      for (int st = 0; st < 6; st++) begin
        case (st)
          0: set_pose(32'h007FFFFF, 32'h007FFFFF, 32'hFFFFC000, 32'd16384, 32'd1);
          1: set_pose(32'hFF800000, 32'hFF800000, 32'd16384, 32'hFFFFC000, 32'd1);
          2: set_pose($urandom, $urandom, trig_reg(), trig_reg(), 32'hFFFFFFFE);
          default: set_pose($urandom, 32'(vel()), trig_reg(), trig_reg(),
                            32'($urandom_range(5) != 0));
        endcase
        repeat (72) send(vel(), vel(), 16'($urandom), idle);
        drain();
      end
    end

    repeat (LATENCY + 8) @(posedge clk);
    $display("%0d commands sent, %0d results checked, %0d mismatches", words_in,
             words_out, fails);
    $display("covered reset pose, extreme and random wheel poses, three idle profiles");
    if (fails == 0 && board.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
